/* rtl/box_circle_collision_push_out_macros.svh */
// Assertion macros for the box/circle collision block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef BOX_CIRCLE_COLLISION_PUSH_OUT_MACROS_SVH
`define BOX_CIRCLE_COLLISION_PUSH_OUT_MACROS_SVH

// same-cycle implication, masked during reset
`define BCCP_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication, live through reset
`define BCCP_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) (ant) |=> (cons)) else $error(msg);

`endif

/* rtl/bccp_pkg.sv */
// Shared types and constants for the box/circle collision pipeline.
// No dependencies.
package bccp_pkg;

  // square root works on a fixed 64-bit radicand, 32 root bits
  localparam int SQ_RAD_W  = 64;
  localparam int SQ_ROOT_W = 32;
  localparam int SQ_REM_W  = 35;

  typedef enum logic [1:0] {
    DIR_LEFT,
    DIR_RIGHT,
    DIR_BOTTOM,
    DIR_TOP
  } bccp_dir_t;

  typedef struct packed {
    logic      hit;
    logic      enclosed;
    bccp_dir_t dir;
  } bccp_flags_t;

endpackage

/* rtl/bccp_geom.sv */
// Front end: box edges, clamp, offsets, squared distance, hit and edge push.
// Four register stages. Depends on bccp_pkg.
module bccp_geom import bccp_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] box_x,
  input  logic signed [COORD_WIDTH-1:0] box_y,
  input  logic        [COORD_WIDTH-2:0] box_width,
  input  logic        [COORD_WIDTH-2:0] box_height,
  input  logic signed [COORD_WIDTH-1:0] circle_x,
  input  logic signed [COORD_WIDTH-1:0] circle_y,
  input  logic        [COORD_WIDTH-3:0] circle_radius,
  output logic                          out_valid,
  output logic        [COORD_WIDTH-1:0] out_dx,
  output logic        [COORD_WIDTH-1:0] out_dy,
  output logic      [2*COORD_WIDTH-1:0] out_s,
  output logic        [COORD_WIDTH-2:0] out_r2,
  output bccp_flags_t                   out_flags,
  output logic        [COORD_WIDTH-1:0] out_len
);

  localparam int W  = COORD_WIDTH;
  localparam int EW = COORD_WIDTH + 3;

  // stage 1: doubled coordinates (Q.1) and box edges
  logic signed [EW-1:0] cx1_nxt, cy1_nxt, bx2, by2, bwe, bhe;
  logic signed [EW-1:0] cx1_r, cy1_r, minx1_r, maxx1_r, miny1_r, maxy1_r;
  logic        [W-2:0]  r2_1_r;
  logic                 v1_r;

  always_comb begin
    cx1_nxt = EW'(circle_x) <<< 1;
    cy1_nxt = EW'(circle_y) <<< 1;
    bx2     = EW'(box_x) <<< 1;
    by2     = EW'(box_y) <<< 1;
    bwe     = EW'({1'b0, box_width});
    bhe     = EW'({1'b0, box_height});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      cx1_r   <= cx1_nxt;
      cy1_r   <= cy1_nxt;
      minx1_r <= bx2 - bwe;
      maxx1_r <= bx2 + bwe;
      miny1_r <= by2 - bhe;
      maxy1_r <= by2 + bhe;
      r2_1_r  <= {circle_radius, 1'b0};
    end
  end

  // stage 2: clamp and offsets, edge distances
  logic signed [EW-1:0] clx, cly;
  logic signed [EW-1:0] dx2_r, dy2_r, el2_r, er2_r, eb2_r, et2_r;
  logic        [W-2:0]  r2_2_r;
  logic                 v2_r;

  always_comb begin
    clx = cx1_r;
    if (cx1_r < minx1_r) begin
      clx = minx1_r;
    end else if (cx1_r > maxx1_r) begin
      clx = maxx1_r;
    end
    cly = cy1_r;
    if (cy1_r < miny1_r) begin
      cly = miny1_r;
    end else if (cy1_r > maxy1_r) begin
      cly = maxy1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      dx2_r  <= cx1_r - clx;
      dy2_r  <= cy1_r - cly;
      el2_r  <= cx1_r - minx1_r;
      er2_r  <= maxx1_r - cx1_r;
      eb2_r  <= cy1_r - miny1_r;
      et2_r  <= maxy1_r - cy1_r;
      r2_2_r <= r2_1_r;
    end
  end

  // stage 3: range check, squares, nearest edge
  logic signed [EW-1:0]  r2e, best_c;
  logic signed [W-1:0]   dxt, dyt;
  logic signed [2*W-1:0] sqx_c, sqy_c;
  bccp_dir_t             dir_c;
  logic                  inr_c;
  logic                  inr3_r, v3_r;
  logic [2*W-1:0]        sqx3_r, sqy3_r;
  logic [2*W-3:0]        rr3_r;
  logic [W-1:0]          best3_r, dx3_r, dy3_r;
  logic [W-2:0]          r2_3_r;
  bccp_dir_t             dir3_r;

  always_comb begin
    r2e   = EW'({1'b0, r2_2_r});
    inr_c = (dx2_r <= r2e) && (dx2_r >= -r2e) && (dy2_r <= r2e) && (dy2_r >= -r2e);
    dxt   = dx2_r[W-1:0];
    dyt   = dy2_r[W-1:0];
    sqx_c = dxt * dxt;
    sqy_c = dyt * dyt;
    // ties keep the earlier edge: left, right, bottom, top
    best_c = el2_r;
    dir_c  = DIR_LEFT;
    if (er2_r < best_c) begin
      best_c = er2_r;
      dir_c  = DIR_RIGHT;
    end
    if (eb2_r < best_c) begin
      best_c = eb2_r;
      dir_c  = DIR_BOTTOM;
    end
    if (et2_r < best_c) begin
      best_c = et2_r;
      dir_c  = DIR_TOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      inr3_r  <= inr_c;
      sqx3_r  <= sqx_c;
      sqy3_r  <= sqy_c;
      rr3_r   <= r2_2_r * r2_2_r;
      best3_r <= best_c[W-1:0];
      dir3_r  <= dir_c;
      dx3_r   <= dxt;
      dy3_r   <= dyt;
      r2_3_r  <= r2_2_r;
    end
  end

  // stage 4: distance sum, hit decision, edge push length
  logic [2*W-1:0] s_nxt;
  logic [W:0]     lsum;
  bccp_flags_t    flags_nxt;
  logic           v4_r;

  always_comb begin
    s_nxt              = sqx3_r + sqy3_r;
    flags_nxt.hit      = inr3_r && (s_nxt <= (2*W)'(rr3_r));
    flags_nxt.enclosed = (s_nxt == '0);
    flags_nxt.dir      = dir3_r;
    lsum               = (W+1)'(best3_r) + (W+1)'(r2_3_r) + (W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
    if (adv) begin
      out_s     <= s_nxt;
      out_flags <= flags_nxt;
      out_len   <= lsum[W:1];
      out_dx    <= dx3_r;
      out_dy    <= dy3_r;
      out_r2    <= r2_3_r;
    end
  end

  assign out_valid = v4_r;

endmodule

/* rtl/bccp_sqrt.sv */
// Pipelined integer square root, one root bit per stage, 32 stages.
// Carries an opaque sideband word alongside. Depends on bccp_pkg.
module bccp_sqrt import bccp_pkg::*; #(
  parameter int SB_W = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [SQ_RAD_W-1:0]  in_x,
  input  logic [SB_W-1:0]      in_sb,
  output logic                 out_valid,
  output logic [SQ_ROOT_W-1:0] out_root,
  output logic [SB_W-1:0]      out_sb
);

  logic [SQ_REM_W-1:0]  rem_r  [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] root_r [SQ_ROOT_W];
  logic [SQ_RAD_W-1:0]  x_r    [SQ_ROOT_W];
  logic [SB_W-1:0]      sb_r   [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] v_r;

  for (genvar i = 0; i < SQ_ROOT_W; i++) begin : g_stage
    logic [SQ_REM_W-1:0]  rem_i, rem_sh, trial;
    logic [SQ_ROOT_W-1:0] root_i;
    logic [SQ_RAD_W-1:0]  x_i;
    logic [SB_W-1:0]      sb_i;
    logic                 v_i, ge;

    if (i == 0) begin : g_head
      assign rem_i  = '0;
      assign root_i = '0;
      assign x_i    = in_x;
      assign sb_i   = in_sb;
      assign v_i    = in_valid;
    end else begin : g_body
      assign rem_i  = rem_r[i-1];
      assign root_i = root_r[i-1];
      assign x_i    = x_r[i-1];
      assign sb_i   = sb_r[i-1];
      assign v_i    = v_r[i-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_i[SQ_REM_W-3:0], x_i[SQ_RAD_W-1 -: 2]};
    assign trial  = SQ_REM_W'({root_i, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= v_i;
      end
      if (adv) begin
        rem_r[i]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[i] <= {root_i[SQ_ROOT_W-2:0], ge};
        x_r[i]    <= x_i << 2;
        sb_r[i]   <= sb_i;
      end
    end
  end

  assign out_valid = v_r[SQ_ROOT_W-1];
  assign out_root  = root_r[SQ_ROOT_W-1];
  assign out_sb    = sb_r[SQ_ROOT_W-1];

endmodule

/* rtl/bccp_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Carries an opaque sideband word alongside. No package use.
module bccp_div #(
  parameter int NUM_W = 57,
  parameter int DEN_W = 34,
  parameter int QUO_W = 24,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output logic [SB_W-1:0]  out_sb
);

  localparam int REM_W = DEN_W + 1;

  logic [REM_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] lo_r  [QUO_W];
  logic [QUO_W-1:0] q_r   [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [SB_W-1:0]  sb_r  [QUO_W];
  logic [QUO_W-1:0] v_r;

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [REM_W-1:0] rem_i, rs, dz;
    logic [QUO_W-1:0] lo_i, q_i;
    logic [DEN_W-1:0] den_i;
    logic [SB_W-1:0]  sb_i;
    logic             v_i, ge;

    if (j == 0) begin : g_head
      assign rem_i = REM_W'(in_num[NUM_W-1:QUO_W]);
      assign lo_i  = in_num[QUO_W-1:0];
      assign q_i   = '0;
      assign den_i = in_den;
      assign sb_i  = in_sb;
      assign v_i   = in_valid;
    end else begin : g_body
      assign rem_i = rem_r[j-1];
      assign lo_i  = lo_r[j-1];
      assign q_i   = q_r[j-1];
      assign den_i = den_r[j-1];
      assign sb_i  = sb_r[j-1];
      assign v_i   = v_r[j-1];
    end

    assign rs = {rem_i[REM_W-2:0], lo_i[QUO_W-1]};
    assign dz = {1'b0, den_i};
    assign ge = (rs >= dz);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (adv) begin
        v_r[j] <= v_i;
      end
      if (adv) begin
        rem_r[j] <= ge ? (rs - dz) : rs;
        lo_r[j]  <= lo_i << 1;
        q_r[j]   <= {q_i[QUO_W-2:0], ge};
        den_r[j] <= den_i;
        sb_r[j]  <= sb_i;
      end
    end
  end

  assign out_valid = v_r[QUO_W-1];
  assign out_quo   = q_r[QUO_W-1];
  assign out_sb    = sb_r[QUO_W-1];

endmodule

/* rtl/box_circle_collision_push_out.sv */
// Box/circle collision with push-out vector. Takes one box/circle pair per
// clock unless stalled and returns hit plus a signed integer (Q24.0) push that
// moves the circle clear of the box. The pipeline holds four front-end stages,
// 32 square-root stages (one root bit each), three stages for overlap, multiply
// and divider set-up, one stage per quotient bit in the dividers and the output
// word register. Throughput is one word per cycle; a stall while an output word
// is valid freezes the whole pipeline.
// Depends on bccp_pkg, bccp_geom, bccp_sqrt, bccp_div and the macros header.
`include "box_circle_collision_push_out_macros.svh"

module box_circle_collision_push_out import bccp_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_box_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_y,
  input  logic        [COORD_WIDTH-2:0] in_box_width,
  input  logic        [COORD_WIDTH-2:0] in_box_height,
  input  logic signed [COORD_WIDTH-1:0] in_circle_x,
  input  logic signed [COORD_WIDTH-1:0] in_circle_y,
  input  logic        [COORD_WIDTH-3:0] in_circle_radius,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic signed   [COORD_WIDTH:0] out_push_x,
  output logic signed   [COORD_WIDTH:0] out_push_y
);

  localparam int W     = COORD_WIDTH;
  localparam int H     = SQ_ROOT_W - W;          // extra root precision
  localparam int OVW   = SQ_ROOT_W - 1;
  localparam int PW    = W + SQ_ROOT_W;           // product width
  localparam int NUM_W = W + 33;
  localparam int DEN_W = SQ_ROOT_W + 2;
  localparam int FLW   = $bits(bccp_flags_t);
  localparam int SB1_W = FLW + 4*W - 1;
  localparam int SB2_W = FLW + W + 1;

  logic adv;
  logic out_valid_r, out_hit_r;
  logic signed [W:0] out_push_x_r, out_push_y_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // front end
  logic           g_valid;
  logic [W-1:0]   g_dx, g_dy, g_len;
  logic [2*W-1:0] g_s;
  logic [W-2:0]   g_r2;
  bccp_flags_t    g_flags;

  bccp_geom #(.COORD_WIDTH(W)) u_geom (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (in_valid),
    .box_x        (in_box_x),
    .box_y        (in_box_y),
    .box_width    (in_box_width),
    .box_height   (in_box_height),
    .circle_x     (in_circle_x),
    .circle_y     (in_circle_y),
    .circle_radius(in_circle_radius),
    .out_valid    (g_valid),
    .out_dx       (g_dx),
    .out_dy       (g_dy),
    .out_s        (g_s),
    .out_r2       (g_r2),
    .out_flags    (g_flags),
    .out_len      (g_len)
  );

  // distance, scaled by 2^H
  logic                 sq_valid;
  logic [SQ_ROOT_W-1:0] sq_root;
  logic [SB1_W-1:0]     sq_sb;

  bccp_sqrt #(.SB_W(SB1_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (g_valid),
    .in_x     (SQ_RAD_W'(g_s) << (2*H)),
    .in_sb    ({g_flags, g_len, g_dx, g_dy, g_r2}),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_sb   (sq_sb)
  );

  bccp_flags_t  s_flags;
  logic [W-1:0] s_len, s_dx, s_dy;
  logic [W-2:0] s_r2;
  logic [SQ_ROOT_W-1:0] r2_sh, ov_c;

  assign {s_flags, s_len, s_dx, s_dy, s_r2} = sq_sb;
  assign r2_sh = SQ_ROOT_W'(s_r2) << H;
  assign ov_c  = r2_sh - sq_root;

  // overlap stage
  logic                 t1_v_r;
  bccp_flags_t          t1_flags_r;
  logic [W-1:0]         t1_len_r, t1_dx_r, t1_dy_r;
  logic [OVW-1:0]       t1_ov_r;
  logic [SQ_ROOT_W-1:0] t1_d_r;

  // multiply stage
  logic                 t2_v_r;
  bccp_flags_t          t2_flags_r;
  logic [W-1:0]         t2_len_r;
  logic signed [PW-1:0] t2_px_r, t2_py_r;
  logic [SQ_ROOT_W-1:0] t2_d_r;

  // divider set-up: round half away from zero as (2|n| + den) / (2 den)
  logic                 t3_v_r;
  bccp_flags_t          t3_flags_r;
  logic [W-1:0]         t3_len_r;
  logic [NUM_W-1:0]     t3_nx_r, t3_ny_r;
  logic [DEN_W-1:0]     t3_den_r;
  logic                 t3_sx_r, t3_sy_r;

  logic signed [W-1:0]  dxs, dys;
  logic signed [PW-1:0] magx, magy;

  assign dxs  = t1_dx_r;
  assign dys  = t1_dy_r;
  assign magx = t2_px_r[PW-1] ? -t2_px_r : t2_px_r;
  assign magy = t2_py_r[PW-1] ? -t2_py_r : t2_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
    end else if (adv) begin
      t1_v_r <= sq_valid;
      t2_v_r <= t1_v_r;
      t3_v_r <= t2_v_r;
    end
    if (adv) begin
      t1_flags_r <= s_flags;
      t1_len_r   <= s_len;
      t1_dx_r    <= s_dx;
      t1_dy_r    <= s_dy;
      t1_ov_r    <= ov_c[OVW-1:0];
      t1_d_r     <= sq_root;

      t2_flags_r <= t1_flags_r;
      t2_len_r   <= t1_len_r;
      t2_px_r    <= dxs * $signed({1'b0, t1_ov_r});
      t2_py_r    <= dys * $signed({1'b0, t1_ov_r});
      t2_d_r     <= t1_d_r;

      t3_flags_r <= t2_flags_r;
      t3_len_r   <= t2_len_r;
      t3_nx_r    <= {magx, 1'b0} + NUM_W'({t2_d_r, 1'b0});
      t3_ny_r    <= {magy, 1'b0} + NUM_W'({t2_d_r, 1'b0});
      t3_den_r   <= {t2_d_r, 2'b00};
      t3_sx_r    <= t2_px_r[PW-1];
      t3_sy_r    <= t2_py_r[PW-1];
    end
  end

  logic             dvx_valid, dvy_valid;
  logic [W-1:0]     qx, qy;
  logic [SB2_W-1:0] dvx_sb;
  logic             dvy_sb;

  bccp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(W), .SB_W(SB2_W)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (t3_v_r),
    .in_num   (t3_nx_r),
    .in_den   (t3_den_r),
    .in_sb    ({t3_flags_r, t3_len_r, t3_sx_r}),
    .out_valid(dvx_valid),
    .out_quo  (qx),
    .out_sb   (dvx_sb)
  );

  bccp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(W), .SB_W(1)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (t3_v_r),
    .in_num   (t3_ny_r),
    .in_den   (t3_den_r),
    .in_sb    (t3_sy_r),
    .out_valid(dvy_valid),
    .out_quo  (qy),
    .out_sb   (dvy_sb)
  );

  // result select
  bccp_flags_t       fin_flags;
  logic [W-1:0]      fin_len;
  logic              fin_sx;
  logic signed [W:0] lenw, qxw, qyw, push_x_nxt, push_y_nxt;

  assign {fin_flags, fin_len, fin_sx} = dvx_sb;
  assign lenw = (W+1)'(fin_len);
  assign qxw  = (W+1)'(qx);
  assign qyw  = (W+1)'(qy);

  always_comb begin
    push_x_nxt = '0;
    push_y_nxt = '0;
    if (fin_flags.hit) begin
      if (fin_flags.enclosed) begin
        unique case (fin_flags.dir)
          DIR_LEFT:   push_x_nxt = -lenw;
          DIR_RIGHT:  push_x_nxt = lenw;
          DIR_BOTTOM: push_y_nxt = -lenw;
          DIR_TOP:    push_y_nxt = lenw;
          default:    push_x_nxt = '0;
        endcase
      end else begin
        push_x_nxt = fin_sx ? -qxw : qxw;
        push_y_nxt = dvy_sb ? -qyw : qyw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dvx_valid;
    end
    if (adv) begin
      out_hit_r    <= fin_flags.hit;
      out_push_x_r <= push_x_nxt;
      out_push_y_r <= push_y_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_hit    = out_hit_r;
  assign out_push_x = out_push_x_r;
  assign out_push_y = out_push_y_r;

  `BCCP_ASSERT_IMP(a_nohit_zero, out_valid_r && !out_hit_r,
                   (out_push_x_r == '0) && (out_push_y_r == '0), "push without hit")
  `BCCP_ASSERT_IMP(a_enclosed_axis,
                   dvx_valid && dvy_valid && fin_flags.hit && fin_flags.enclosed,
                   (push_x_nxt == '0) || (push_y_nxt == '0), "edge push on two axes")
  `BCCP_ASSERT_NXT(a_rst_empty, !rst_n, !out_valid_r, "output valid after reset")

endmodule

/* test/testbench.sv */
// Testbench for box_circle_collision_push_out: directed and random box/circle
// pairs, predicted push-out words checked against the block's output stream.
// Depends on the RTL top level and bccp_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 24;
  localparam int OW = CW + 1;
  localparam int LATENCY = CW + 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [CW-1:0] box_x;
    logic signed [CW-1:0] box_y;
    logic [CW-2:0] box_width;
    logic [CW-2:0] box_height;
    logic signed [CW-1:0] circle_x;
    logic signed [CW-1:0] circle_y;
    logic [CW-3:0] circle_radius;
  } pair_t;

  typedef struct {
    logic hit;
    logic signed [OW-1:0] push_x;
    logic signed [OW-1:0] push_y;
  } push_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [CW-1:0] in_box_x = '0, in_box_y = '0, in_circle_x = '0, in_circle_y = '0;
  logic [CW-2:0] in_box_width = '0, in_box_height = '0;
  logic [CW-3:0] in_circle_radius = '0;
  logic out_valid;
  logic out_stall = 0;
  logic out_hit;
  logic signed [OW-1:0] out_push_x, out_push_y;

  pair_t pending_pairs[$];
  push_t expected_pushes[$];
  int mismatches = 0;
  int cycles = 0;
  bit stimulus_done = 0;
  bit calm = 0;
  bit in_taken = 0;

  box_circle_collision_push_out #(.COORD_WIDTH(CW)) DUT (.*);

  always #2 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint unsigned mag;
    longint unsigned q;
    mag = num < 0 ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [OW-1:0] saturate(longint v);
    longint lim;
    lim = longint'(1) <<< (OW - 1);
    if (v < -lim) v = -lim;
    if (v > lim - 1) v = lim - 1;
    return v[OW-1:0];
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // everything in doubled units so half sizes stay exact
  function automatic push_t predict_push(pair_t p);
    longint cx, cy, r2, minx, maxx, miny, maxy, dx, dy, px, py, best, len, ov;
    longint unsigned s, d;
    bccp_pkg::bccp_dir_t dir;
    push_t res;
    cx = 2 * longint'(p.circle_x);
    cy = 2 * longint'(p.circle_y);
    r2 = 2 * longint'({1'b0, p.circle_radius});
    minx = 2 * longint'(p.box_x) - longint'({1'b0, p.box_width});
    maxx = 2 * longint'(p.box_x) + longint'({1'b0, p.box_width});
    miny = 2 * longint'(p.box_y) - longint'({1'b0, p.box_height});
    maxy = 2 * longint'(p.box_y) + longint'({1'b0, p.box_height});
    dx = cx - clip(cx, minx, maxx);
    dy = cy - clip(cy, miny, maxy);
    px = 0;
    py = 0;
    res.hit = 0;
    if (dx <= r2 && dx >= -r2 && dy <= r2 && dy >= -r2) begin
      s = dx * dx + dy * dy;
      if (s <= r2 * r2) begin
        res.hit = 1;
        if (s == 0) begin
          best = cx - minx;
          dir = bccp_pkg::DIR_LEFT;
          if (maxx - cx < best) begin best = maxx - cx; dir = bccp_pkg::DIR_RIGHT; end
          if (cy - miny < best) begin best = cy - miny; dir = bccp_pkg::DIR_BOTTOM; end
          if (maxy - cy < best) begin best = maxy - cy; dir = bccp_pkg::DIR_TOP; end
          len = (best + r2 + 1) >>> 1;
          case (dir)
            bccp_pkg::DIR_LEFT: px = -len;
            bccp_pkg::DIR_RIGHT: px = len;
            bccp_pkg::DIR_BOTTOM: py = -len;
            default: py = len;
          endcase
        end else begin
          d = int_sqrt(s << (2 * (32 - CW)));
          ov = (r2 <<< (32 - CW)) - longint'(d);
          px = round_div(dx * ov, 2 * longint'(d));
          py = round_div(dy * ov, 2 * longint'(d));
        end
      end
    end
    res.push_x = saturate(px);
    res.push_y = saturate(py);
    return res;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int span;
    case ($urandom_range(0, 5))
      0: begin
        p.box_x = CW'($urandom);
        p.box_y = CW'($urandom);
        p.box_width = (CW-1)'($urandom);
        p.box_height = (CW-1)'($urandom);
        p.circle_x = CW'($urandom);
        p.circle_y = CW'($urandom);
        p.circle_radius = (CW-2)'($urandom);
      end
      default: begin
        // near-contact geometry in a small scale so hits and misses both occur
        span = 1 << $urandom_range(4, 20);
        p.box_x = CW'($urandom);
        p.box_y = CW'($urandom);
        p.box_width = (CW-1)'($urandom_range(0, span));
        p.box_height = (CW-1)'($urandom_range(0, span));
        p.circle_radius = (CW-2)'($urandom_range(0, span));
        p.circle_x = CW'(p.box_x + $signed($urandom_range(0, 4 * span)) - 2 * span);
        p.circle_y = CW'(p.box_y + $signed($urandom_range(0, 4 * span)) - 2 * span);
      end
    endcase
    return p;
  endfunction

  function automatic pair_t make_pair(int bx, int by, int bw, int bh, int cx, int cy, int r);
    pair_t p;
    p.box_x = CW'(bx);
    p.box_y = CW'(by);
    p.box_width = (CW-1)'(bw);
    p.box_height = (CW-1)'(bh);
    p.circle_x = CW'(cx);
    p.circle_y = CW'(cy);
    p.circle_radius = (CW-2)'(r);
    return p;
  endfunction

  initial begin
    // centre inside, each nearest edge, ties, touching, miss, corner, extremes
    pending_pairs.push_back(make_pair(0, 0, 2560, 2560, -1000, 0, 256));
    pending_pairs.push_back(make_pair(0, 0, 2560, 2560, 1000, 0, 256));
    pending_pairs.push_back(make_pair(0, 0, 2560, 2560, 0, -1000, 256));
    pending_pairs.push_back(make_pair(0, 0, 2560, 2560, 0, 1000, 256));
    pending_pairs.push_back(make_pair(0, 0, 2560, 2560, 0, 0, 256));
    pending_pairs.push_back(make_pair(0, 0, 2561, 2560, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 512, 512, 512, 0, 256));
    pending_pairs.push_back(make_pair(0, 0, 512, 512, 513, 0, 256));
    pending_pairs.push_back(make_pair(0, 0, 512, 512, 400, 400, 256));
    pending_pairs.push_back(make_pair(0, 0, 512, 512, 430, 430, 256));
    pending_pairs.push_back(make_pair(0, 0, 512, 512, -300, -300, 200));
    pending_pairs.push_back(make_pair(-8388608, -8388608, 8388607, 8388607,
                                      8388607, 8388607, 4194303));
    pending_pairs.push_back(make_pair(8388607, 8388607, 8388607, 8388607,
                                      -8388608, -8388608, 4194303));
    pending_pairs.push_back(make_pair(0, 0, 8388607, 8388607, 0, 0, 4194303));
    pending_pairs.push_back(make_pair(8388607, -8388608, 0, 8388607,
                                      8388607, 0, 4194303));
    pending_pairs.push_back(make_pair(-8388608, 8388607, 8388607, 0,
                                      -8388608, 8388607, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 4194303, 0, 4194303));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, -8388608, 4194303));
    pending_pairs.push_back(make_pair(-1, -1, 1, 1, 1, 1, 1));
    repeat (1050) pending_pairs.push_back(random_pair());
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  // quiet stretch in the middle of the run
  always @(posedge clk) calm <= (cycles > 300 && cycles < 600);

  // whether the word on the input was taken at the last rising edge
  always @(posedge clk) in_taken <= in_valid && !in_stall;

  // driver: new word only once the current one has gone
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_pairs.size() != 0 && (calm || $urandom_range(0, 99) >= 19)) begin
          pair_t p;
          p = pending_pairs.pop_front();
          in_valid <= 1'b1;
          in_box_x <= p.box_x;
          in_box_y <= p.box_y;
          in_box_width <= p.box_width;
          in_box_height <= p.box_height;
          in_circle_x <= p.circle_x;
          in_circle_y <= p.circle_y;
          in_circle_radius <= p.circle_radius;
        end else begin
          in_valid <= 1'b0;
          if (pending_pairs.size() == 0) stimulus_done <= 1'b1;
        end
      end
      out_stall <= !calm && $urandom_range(0, 99) < 19;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pair_t p;
        p.box_x = in_box_x;
        p.box_y = in_box_y;
        p.box_width = in_box_width;
        p.box_height = in_box_height;
        p.circle_x = in_circle_x;
        p.circle_y = in_circle_y;
        p.circle_radius = in_circle_radius;
        expected_pushes.push_back(predict_push(p));
      end
      if (out_valid && !out_stall) begin
        push_t e;
        if (expected_pushes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: hit %0b push %0d %0d",
                                         out_hit, out_push_x, out_push_y);
        end else begin
          e = expected_pushes.pop_front();
          if (out_hit !== e.hit || out_push_x !== e.push_x || out_push_y !== e.push_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected hit %0b push %0d %0d, got hit %0b push %0d %0d",
                       e.hit, e.push_x, e.push_y, out_hit, out_push_x, out_push_y);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done && !in_valid);
    while (expected_pushes.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && expected_pushes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
